>>> hdl/mhd_pkg.sv
// Shared types, constants and the character table for the Morse hex decoder.
// Used by the front end, back end, top level and checker; has no dependencies of its own.
package mhd_pkg;

   localparam int TABLE_DEPTH = 30;
   localparam int QUEUE_DEPTH = 4;
   localparam int ADDR_WIDTH  = 4;
   localparam int DATA_WIDTH  = 32;

   localparam logic [5:0] IDX_EMPTY = 6'd63;
   localparam logic [5:0] IDX_OVER  = 6'd62;
   localparam logic [6:0] CHAR_STAR = 7'h2A;

   localparam logic [1:0] REG_ENABLE    = 2'd0;
   localparam logic [1:0] REG_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_DOT_UNIT  = 2'd2;

   localparam logic [0:0] EVENT_LETTER = 1'b0;
   localparam logic [0:0] EVENT_WORD   = 1'b1;

   localparam logic [9:0]  THRESHOLD_RESET = 10'd700;
   localparam logic [10:0] DOT_UNIT_RESET  = 11'd92;

   // "547263EDCB9810/F******A*******"
   localparam logic [6:0] CODE_ROM [TABLE_DEPTH] = '{
      7'h35, 7'h34, 7'h37, 7'h32, 7'h36, 7'h33, 7'h45, 7'h44, 7'h43, 7'h42,
      7'h39, 7'h38, 7'h31, 7'h30, 7'h2F, 7'h46, 7'h2A, 7'h2A, 7'h2A, 7'h2A,
      7'h2A, 7'h2A, 7'h41, 7'h2A, 7'h2A, 7'h2A, 7'h2A, 7'h2A, 7'h2A, 7'h2A
   };

   typedef struct packed {
      logic        enable;
      logic [9:0]  on_threshold;
      logic [10:0] dot_unit_ms;
   } cfg_type;

   typedef struct packed {
      logic        tone_hit;
      logic [31:0] time_ms;
   } sample_type;

   typedef struct packed {
      logic       event_kind;
      logic [6:0] letter;
   } result_type;

endpackage

>>> hdl/mhd_queue.sv
// Small first-in first-out queue on a register array.
// Generic; used for the classified samples and for the results. No package use.
module mhd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/mhd_front.sv
// Front end: takes samples, drops them while disabled, flags tone against threshold.
// Depends on mhd_pkg for the configuration and sample types.
module mhd_front (
   input  mhd_pkg::cfg_type    cfg,
   input  logic                req_push,
   input  logic [9:0]          req_sample,
   input  logic [31:0]         req_time_ms,
   input  logic                queue_full,
   output logic                req_full,
   output logic                queue_push,
   output mhd_pkg::sample_type queue_data
);

   assign req_full            = queue_full;
   // a disabled step changes nothing, so it never reaches the back end
   assign queue_push          = req_push & ~queue_full & cfg.enable;
   assign queue_data.tone_hit = (req_sample > cfg.on_threshold);
   assign queue_data.time_ms  = req_time_ms;

endmodule

>>> hdl/mhd_back.sv
// Back end: debounce, span timing, code tree walk and letter/word emission.
// Depends on mhd_pkg for types, the code table and tree constants.
module mhd_back (
   input  logic                clock,
   input  logic                reset,
   input  mhd_pkg::cfg_type    cfg,
   input  logic                in_empty,
   input  mhd_pkg::sample_type in_data,
   output logic                in_pop,
   input  logic                out_full,
   output logic                out_push,
   output mhd_pkg::result_type out_data
);

   logic        level_ff, level_in;
   logic        tone_on_ff, tone_on_in;
   logic        word_started_ff, word_started_in;
   logic        letter_done_ff, letter_done_in;
   logic [5:0]  tree_index_ff, tree_index_in;
   logic [31:0] last_change_ff, last_change_in;
   logic [31:0] last_on_ff, last_on_in;

   logic        fire, emit;
   logic [31:0] now, interval;
   logic [9:0]  debounce;
   logic [11:0] letter_space;
   logic [12:0] word_space;
   logic        dah;
   logic [6:0]  tree_inc, tree_next;
   logic [6:0]  rom_char;

   assign fire         = ~in_empty & ~out_full;
   assign in_pop       = fire;
   assign out_push     = fire & emit;
   assign now          = in_data.time_ms;
   assign debounce     = cfg.dot_unit_ms[10:1];
   assign letter_space = {cfg.dot_unit_ms, 1'b0};
   assign word_space   = {cfg.dot_unit_ms, 2'b00};

   // (t+1)*2 + dah, saturating past the table
   assign tree_inc  = {1'b0, tree_index_ff} + 7'd1;

   assign rom_char = (tree_index_ff < 6'(mhd_pkg::TABLE_DEPTH))
                   ? mhd_pkg::CODE_ROM[tree_index_ff[4:0]] : mhd_pkg::CHAR_STAR;

   always_comb begin
      level_in        = level_ff;
      tone_on_in      = tone_on_ff;
      word_started_in = word_started_ff;
      letter_done_in  = letter_done_ff;
      tree_index_in   = tree_index_ff;
      last_change_in  = last_change_ff;
      last_on_in      = last_on_ff;
      interval        = '0;
      dah             = 1'b0;
      tree_next       = '0;
      emit            = 1'b0;
      out_data        = '0;

      // debounce
      if (in_data.tone_hit) begin
         level_in   = 1'b1;
         last_on_in = now;
      end else if ((now - last_on_ff) > 32'(debounce)) begin
         level_in = 1'b0;
      end else if (now < last_on_ff) begin
         last_on_in = '0;
      end

      // span edges
      if (level_in) begin
         if (!tone_on_ff) begin
            if (word_started_ff) begin
               interval = now - last_change_ff;
            end
            tone_on_in      = 1'b1;
            last_change_in  = now;
            word_started_in = 1'b1;
         end
      end else begin
         interval = now - last_change_ff;
         if (tone_on_ff && word_started_ff) begin
            tone_on_in     = 1'b0;
            last_change_in = now;
            letter_done_in = 1'b0;
         end
      end

      if (interval != '0 && !tone_on_in && last_change_in == now) begin
         if (tree_index_ff != mhd_pkg::IDX_OVER) begin
            dah = (interval > 32'(letter_space));
            if (tree_index_ff == mhd_pkg::IDX_EMPTY) begin
               tree_next = {6'd0, dah};
            end else begin
               tree_next = {tree_inc[5:0], dah};
            end
            tree_index_in = (tree_next < 7'(mhd_pkg::TABLE_DEPTH))
                          ? tree_next[5:0] : mhd_pkg::IDX_OVER;
         end
      end else if (interval != '0 && word_started_in) begin
         if (!letter_done_in && interval > 32'(letter_space)) begin
            letter_done_in      = 1'b1;
            tree_index_in       = mhd_pkg::IDX_EMPTY;
            emit                = 1'b1;
            out_data.event_kind = mhd_pkg::EVENT_LETTER;
            out_data.letter     = rom_char;
         end else if (interval > 32'(word_space)) begin
            tone_on_in          = 1'b0;
            word_started_in     = 1'b0;
            letter_done_in      = 1'b0;
            tree_index_in       = mhd_pkg::IDX_EMPTY;
            last_change_in      = '0;
            last_on_in          = '0;
            emit                = 1'b1;
            out_data.event_kind = mhd_pkg::EVENT_WORD;
            out_data.letter     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff        <= 1'b0;
         tone_on_ff      <= 1'b0;
         word_started_ff <= 1'b0;
         letter_done_ff  <= 1'b0;
         tree_index_ff   <= mhd_pkg::IDX_EMPTY;
         last_change_ff  <= '0;
         last_on_ff      <= '0;
      end else if (fire) begin
         level_ff        <= level_in;
         tone_on_ff      <= tone_on_in;
         word_started_ff <= word_started_in;
         letter_done_ff  <= letter_done_in;
         tree_index_ff   <= tree_index_in;
         last_change_ff  <= last_change_in;
         last_on_ff      <= last_on_in;
      end
   end

endmodule

>>> hdl/morse_hex_decoder.sv
// Morse hex decoder top level: register file, front end, sample queue, back end, result queue.
// A sample is held in the sample queue, its result in the result queue behind the rsp_ ports.
// Throughput: one sample per cycle; a full result queue holds the back end, then the input.
// Reset (synchronous): queues empty, decoder state cleared, registers to their defaults.
// Depends on mhd_pkg, mhd_queue, mhd_front and mhd_back.
module morse_hex_decoder #(
   parameter int QUEUE_DEPTH = mhd_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [9:0]                      req_sample,
   input  logic [31:0]                     req_time_ms,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_event_kind,
   output logic [6:0]                      rsp_letter,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mhd_pkg::ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [mhd_pkg::DATA_WIDTH-1:0]  csr_pwdata,
   output logic [mhd_pkg::DATA_WIDTH-1:0]  csr_prdata,
   output logic                            csr_pready
);

   mhd_pkg::cfg_type    cfg_ff, cfg_in;
   mhd_pkg::sample_type front_data, mid_data;
   mhd_pkg::result_type back_data, rsp_data;
   logic                front_push, mid_full, mid_empty, mid_pop;
   logic                back_push, out_full;
   logic                csr_write;
   logic [1:0]          csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            mhd_pkg::REG_ENABLE:    cfg_in.enable       = csr_pwdata[0];
            mhd_pkg::REG_THRESHOLD: cfg_in.on_threshold = csr_pwdata[9:0];
            mhd_pkg::REG_DOT_UNIT:  cfg_in.dot_unit_ms  = csr_pwdata[10:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         mhd_pkg::REG_ENABLE:    csr_prdata = {31'd0, cfg_ff.enable};
         mhd_pkg::REG_THRESHOLD: csr_prdata = {22'd0, cfg_ff.on_threshold};
         mhd_pkg::REG_DOT_UNIT:  csr_prdata = {21'd0, cfg_ff.dot_unit_ms};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable       <= 1'b0;
         cfg_ff.on_threshold <= mhd_pkg::THRESHOLD_RESET;
         cfg_ff.dot_unit_ms  <= mhd_pkg::DOT_UNIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mhd_front u_front (
      .cfg         (cfg_ff),
      .req_push    (req_push),
      .req_sample  (req_sample),
      .req_time_ms (req_time_ms),
      .queue_full  (mid_full),
      .req_full    (req_full),
      .queue_push  (front_push),
      .queue_data  (front_data)
   );

   mhd_queue #(
      .WIDTH ($bits(mhd_pkg::sample_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_data),
      .pop       (mid_pop),
      .head_data (mid_data),
      .full      (mid_full),
      .empty     (mid_empty)
   );

   mhd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_empty (mid_empty),
      .in_data  (mid_data),
      .in_pop   (mid_pop),
      .out_full (out_full),
      .out_push (back_push),
      .out_data (back_data)
   );

   mhd_queue #(
      .WIDTH ($bits(mhd_pkg::result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_data),
      .pop       (rsp_pop),
      .head_data (rsp_data),
      .full      (out_full),
      .empty     (rsp_empty)
   );

   assign rsp_event_kind = rsp_data.event_kind;
   assign rsp_letter     = rsp_data.letter;

endmodule

>>> hdl/mhd_checker.sv
// Port-level checks for the Morse hex decoder, bound to the top level.
// Depends on mhd_pkg and morse_hex_decoder.
module mhd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_event_kind,
   input logic [6:0] rsp_letter,
   input logic       csr_pready
);

   // the result queue comes out of reset empty
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_word_no_char: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_event_kind == mhd_pkg::EVENT_WORD) |-> rsp_letter == 7'd0)
      else $error("word transaction carries a character");

   a_letter_has_char: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_event_kind == mhd_pkg::EVENT_LETTER) |-> rsp_letter != 7'd0)
      else $error("letter transaction without a character");

   a_letter_set: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_event_kind == mhd_pkg::EVENT_LETTER) |->
         (rsp_letter == mhd_pkg::CHAR_STAR || rsp_letter == 7'h2F ||
          (rsp_letter >= 7'h30 && rsp_letter <= 7'h39) ||
          (rsp_letter >= 7'h41 && rsp_letter <= 7'h46)))
      else $error("letter outside the code alphabet");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port stalled");

endmodule

bind morse_hex_decoder mhd_checker u_mhd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_event_kind (rsp_event_kind),
   .rsp_letter     (rsp_letter),
   .csr_pready     (csr_pready)
);
